FILE: rtl/hst_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the head-split tile address generator.
// Depends on nothing; every other file depends on it.
package hst_pkg;

   // Field widths of the channels and registers.
   localparam int WU_W     = 24;   // work unit index
   localparam int GC_W     = 7;    // group_count, heads_in_group, tiles_per_head
   localparam int TPR_W    = 13;   // tiles_per_row
   localparam int RPB_W    = 13;   // rows_per_batch
   localparam int TB_W     = 17;   // tile_bytes
   localparam int ADDR_W   = 32;   // output_address, tensor_address
   localparam int PAGE_W   = 32;   // page_index
   localparam int OFFS_W   = 23;   // local_offset
   localparam int GT_W     = 2 * GC_W;  // tiles in one head group

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Longest run of descriptors produced for one work unit.
   localparam int MAX_RUN_TILES = 64;
   localparam int RUN_W         = $clog2(MAX_RUN_TILES + 1);

   // Divider: quotient bits resolved per cycle and number of passes.
   localparam int DIV_BITS  = 8;
   localparam int DIV_PASS  = WU_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_PASS);

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [GC_W-1:0]   RST_GROUP_COUNT    = GC_W'(16);
   localparam logic [GC_W-1:0]   RST_HEADS_IN_GROUP = GC_W'(1);
   localparam logic [GC_W-1:0]   RST_TILES_PER_HEAD = GC_W'(2);
   localparam logic [TPR_W-1:0]  RST_TILES_PER_ROW  = TPR_W'(32);
   localparam logic [RPB_W-1:0]  RST_ROWS_PER_BATCH = RPB_W'(16);
   localparam logic [TB_W-1:0]   RST_TILE_BYTES     = TB_W'(2048);
   localparam logic [ADDR_W-1:0] RST_OUTPUT_ADDRESS = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GROUP_COUNT    = 3'd0,
      REG_HEADS_IN_GROUP = 3'd1,
      REG_TILES_PER_HEAD = 3'd2,
      REG_TILES_PER_ROW  = 3'd3,
      REG_ROWS_PER_BATCH = 3'd4,
      REG_TILE_BYTES     = 3'd5,
      REG_OUTPUT_ADDRESS = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [GC_W-1:0]   group_count;
      logic [GC_W-1:0]   heads_in_group;
      logic [GC_W-1:0]   tiles_per_head;
      logic [TPR_W-1:0]  tiles_per_row;
      logic [RPB_W-1:0]  rows_per_batch;
      logic [TB_W-1:0]   tile_bytes;
      logic [ADDR_W-1:0] output_address;
   } cfg_type;

   // One run to be emitted: first page and number of tiles.
   typedef struct packed {
      logic [PAGE_W-1:0] base;
      logic [RUN_W-1:0]  run;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_DIV,
      FS_MUL,
      FS_SUM
   } front_state_type;

endpackage

FILE: rtl/hst_if.sv
`timescale 1ns / 1ps
// Handshake channels of the head-split tile address generator: request,
// response and configuration write. Depends on hst_pkg for field widths.
interface hst_req_if;
   logic                     valid;
   logic                     ready;
   logic [hst_pkg::WU_W-1:0] unit_index;

   modport source (output valid, output unit_index, input ready);
   modport sink   (input valid, input unit_index, output ready);
endinterface

interface hst_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hst_pkg::PAGE_W-1:0] page_index;
   logic [hst_pkg::OFFS_W-1:0] local_offset;
   logic [hst_pkg::ADDR_W-1:0] tensor_address;
   logic                       run_last;

   modport source (output valid, output page_index, output local_offset,
                   output tensor_address, output run_last, input ready);
   modport sink   (input valid, input page_index, input local_offset,
                   input tensor_address, input run_last, output ready);
endinterface

interface hst_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hst_pkg::CSR_IDX_W-1:0]  index;
   logic [hst_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/head_split_tile_address_gen.sv
`timescale 1ns / 1ps
// Top level of the head-split tile address generator.
// Depends on hst_pkg, hst_if, hst_csr, hst_front, hst_queue and hst_back.

// Each request word carries a work unit index, which the block splits into
// head group (remainder by group_count) and tile row block (quotient), then
// turns into a base output page and a run of write descriptors, one response
// word per tile, the final word of the run flagged by run_last. A run holds
// heads_in_group times tiles_per_head tiles, capped at 64, and a work unit
// whose run is empty yields no words at all. The front end accepts a work
// unit, runs the divider, which resolves eight quotient bits a cycle, does
// the multiplies, then forms the base page and posts the job, waiting while
// the job queue is full; it takes no new work unit until then. A two-entry
// job queue separates it from the back end, which loads a job and then
// emits one descriptor per cycle while the response side keeps up. The
// response is registered; a word waiting to be taken stalls the back end,
// and the front end waits only once the job queue is full. Configuration
// registers sit on their own write port, which is always ready; they should
// only be changed while no work unit is in flight. There is no clearing
// pass after reset.
module head_split_tile_address_gen (
   input  logic     clock,
   input  logic     reset,
   hst_req_if.sink  req_ch,
   hst_rsp_if.source rsp_ch,
   hst_csr_if.sink  csr_ch
);
   import hst_pkg::*;

   cfg_type          cfg;
   queue_status_type qstat;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   // Register bank feeding both halves.
   hst_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Division and base page computation.
   hst_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg),
      .qstat  (qstat),
      .push   (push),
      .job    (push_job)
   );

   // Jobs waiting for the back end.
   hst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // Descriptor emission, one word per tile.
   hst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head_job (head_job),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: rtl/hst_csr.sv
`timescale 1ns / 1ps
// Configuration register bank of the head-split tile address generator.
// Depends on hst_pkg and hst_if.
module hst_csr (
   input  logic             clock,
   input  logic             reset,
   hst_csr_if.sink          csr_ch,
   output hst_pkg::cfg_type cfg
);
   import hst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_GROUP_COUNT:    cfg_in.group_count    = csr_ch.data[GC_W-1:0];
            REG_HEADS_IN_GROUP: cfg_in.heads_in_group = csr_ch.data[GC_W-1:0];
            REG_TILES_PER_HEAD: cfg_in.tiles_per_head = csr_ch.data[GC_W-1:0];
            REG_TILES_PER_ROW:  cfg_in.tiles_per_row  = csr_ch.data[TPR_W-1:0];
            REG_ROWS_PER_BATCH: cfg_in.rows_per_batch = csr_ch.data[RPB_W-1:0];
            REG_TILE_BYTES:     cfg_in.tile_bytes     = csr_ch.data[TB_W-1:0];
            REG_OUTPUT_ADDRESS: cfg_in.output_address = csr_ch.data[ADDR_W-1:0];
            default:            cfg_in = cfg_ff;   // unknown index is ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_count    <= RST_GROUP_COUNT;
         cfg_ff.heads_in_group <= RST_HEADS_IN_GROUP;
         cfg_ff.tiles_per_head <= RST_TILES_PER_HEAD;
         cfg_ff.tiles_per_row  <= RST_TILES_PER_ROW;
         cfg_ff.rows_per_batch <= RST_ROWS_PER_BATCH;
         cfg_ff.tile_bytes     <= RST_TILE_BYTES;
         cfg_ff.output_address <= RST_OUTPUT_ADDRESS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/hst_front.sv
`timescale 1ns / 1ps
// Front end: accepts a work unit, splits it by division and computes the
// base page and run length of its descriptors. Depends on hst_pkg, hst_if.
module hst_front (
   input  logic                      clock,
   input  logic                      reset,
   hst_req_if.sink                   req_ch,
   input  hst_pkg::cfg_type          cfg,
   input  hst_pkg::queue_status_type qstat,
   output logic                      push,
   output hst_pkg::job_type          job
);
   import hst_pkg::*;

   front_state_type state_ff, state_in;
   logic [WU_W-1:0]      quo_ff, quo_in;      // dividend, then quotient (block)
   logic [GC_W-1:0]      rem_ff, rem_in;      // remainder (group)
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [GT_W-1:0]      gt_ff, gt_in;        // tiles in one head group
   logic [PAGE_W-1:0]    rowpart_ff, rowpart_in;
   logic [GC_W+GT_W-1:0] grppart_ff, grppart_in;
   logic [RUN_W-1:0]     run_ff, run_in;

   logic [GC_W-1:0]      gdiv;
   logic [GC_W:0]        trial;
   logic [WU_W-1:0]      div_quo;
   logic [GC_W-1:0]      div_rem;
   logic [GT_W-1:0]      tiles_in_group;
   logic [WU_W+TPR_W-1:0] row_prod;
   logic [GC_W+GT_W-1:0] grp_prod;

   // A zero group count divides as one.
   assign gdiv = (cfg.group_count == '0) ? GC_W'(1) : cfg.group_count;

   assign tiles_in_group = GT_W'(cfg.heads_in_group) * GT_W'(cfg.tiles_per_head);
   assign row_prod    = {{TPR_W{1'b0}}, quo_ff} * {{WU_W{1'b0}}, cfg.tiles_per_row};
   assign grp_prod    = {{GT_W{1'b0}}, rem_ff} * {{GC_W{1'b0}}, gt_ff};

   // One pass of restoring division: DIV_BITS quotient bits.
   always_comb begin
      div_quo = quo_ff;
      div_rem = rem_ff;
      trial   = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial   = {div_rem, div_quo[WU_W-1]};
         div_quo = {div_quo[WU_W-2:0], 1'b0};
         if (trial >= {1'b0, gdiv}) begin
            div_rem    = GC_W'(trial - {1'b0, gdiv});
            div_quo[0] = 1'b1;
         end else begin
            div_rem = trial[GC_W-1:0];
         end
      end
   end

   assign job.base = rowpart_ff + PAGE_W'(grppart_ff);
   assign job.run  = run_ff;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      gt_in        = gt_ff;
      rowpart_in   = rowpart_ff;
      grppart_in   = grppart_ff;
      run_in       = run_ff;
      push         = 1'b0;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               quo_in   = req_ch.unit_index;
               rem_in   = '0;
               cnt_in   = '0;
               gt_in    = tiles_in_group;
               state_in = FS_DIV;
            end
         end
         FS_DIV: begin
            quo_in = div_quo;
            rem_in = div_rem;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_PASS - 1)) begin
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            // batch*rows*tpr + row*tpr collapses to block*tpr, except that a
            // zero rows_per_batch leaves that whole term at zero.
            rowpart_in = (cfg.rows_per_batch == '0) ? '0 : row_prod[PAGE_W-1:0];
            grppart_in = grp_prod;
            run_in     = (gt_ff > GT_W'(MAX_RUN_TILES)) ? RUN_W'(MAX_RUN_TILES)
                                                         : gt_ff[RUN_W-1:0];
            state_in   = FS_SUM;
         end
         FS_SUM: begin
            if (run_ff == '0) begin
               state_in = FS_IDLE;        // empty run: nothing to emit
            end else if (!qstat.full) begin
               push     = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      gt_ff      <= gt_in;
      rowpart_ff <= rowpart_in;
      grppart_ff <= grppart_in;
      run_ff     <= run_in;
   end

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == FS_MUL |-> rem_ff < gdiv)
      else $error("division remainder not below divisor");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full && run_ff != '0)
      else $error("job pushed into full queue or with empty run");
`endif

endmodule

FILE: rtl/hst_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the descriptor back end.
// Depends on hst_pkg.
module hst_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hst_pkg::job_type          push_job,
   input  logic                      pop,
   output hst_pkg::job_type          head_job,
   output hst_pkg::queue_status_type qstat
);
   import hst_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_job    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("job taken from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy beyond its depth");
`endif

endmodule

FILE: rtl/hst_back.sv
`timescale 1ns / 1ps
// Back end: takes a job from the queue and emits one descriptor word per tile
// through a registered response stage. Depends on hst_pkg and hst_if.
module hst_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hst_pkg::cfg_type          cfg,
   input  hst_pkg::job_type          head_job,
   input  hst_pkg::queue_status_type qstat,
   output logic                      pop,
   hst_rsp_if.source                 rsp_ch
);
   import hst_pkg::*;

   logic              active_ff, active_in;
   logic [PAGE_W-1:0] base_ff, base_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [RUN_W-1:0]  tile_ff, tile_in;
   logic              valid_ff, valid_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              last_ff, last_in;

   logic                  advance;
   logic                  is_last;
   logic [RUN_W+TB_W-1:0] offs_prod;

   assign pop       = !active_ff && !qstat.empty;
   assign advance   = active_ff && (!valid_ff || rsp_ch.ready);
   assign is_last   = (tile_ff + RUN_W'(1)) == run_ff;
   assign offs_prod = {{TB_W{1'b0}}, tile_ff} * {{RUN_W{1'b0}}, cfg.tile_bytes};

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.page_index     = page_ff;
   assign rsp_ch.local_offset   = offs_ff;
   assign rsp_ch.tensor_address = addr_ff;
   assign rsp_ch.run_last       = last_ff;

   always_comb begin
      active_in = active_ff;
      base_in   = base_ff;
      run_in    = run_ff;
      tile_in   = tile_ff;
      valid_in  = valid_ff;
      page_in   = page_ff;
      offs_in   = offs_ff;
      addr_in   = addr_ff;
      last_in   = last_ff;
      if (pop) begin
         active_in = 1'b1;
         base_in   = head_job.base;
         run_in    = head_job.run;
         tile_in   = '0;
      end
      if (advance) begin
         valid_in = 1'b1;
         page_in  = base_ff + PAGE_W'(tile_ff);
         offs_in  = offs_prod[OFFS_W-1:0];
         addr_in  = cfg.output_address;
         last_in  = is_last;
         tile_in  = tile_ff + RUN_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      run_ff  <= run_in;
      tile_ff <= tile_in;
      page_ff <= page_in;
      offs_ff <= offs_in;
      addr_ff <= addr_in;
      last_ff <= last_in;
   end

`ifndef ASSERT_OFF
   a_tile_in_run: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> tile_ff < run_ff && run_ff != '0)
      else $error("tile counter outside its run");
`endif

endmodule

FILE: tb/tb_head_split_tile_address_gen.sv
`timescale 1ns / 1ps
// Self-checking testbench for the head-split tile address generator: a directed
// and a randomised stream of work units, each checked word by word on the way out.
// Depends on hst_pkg, the channel interfaces in hst_if and the block's top level.
module tb_head_split_tile_address_gen;
   import hst_pkg::*;

   // Clock period halves, reset length, settling time for units that produce no words,
   // a guard on the length of the run, and the number and size of random phases.
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_UNITS   = 30;

   // An index outside the register map; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // One descriptor word as it should leave the block.
   typedef struct packed {
      logic [PAGE_W-1:0] page_index;
      logic [OFFS_W-1:0] local_offset;
      logic [ADDR_W-1:0] tensor_address;
      logic              run_last;
   } tile_desc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Everything the testbench drives, held at known values from time zero.
   logic                  req_valid = 1'b0;
   logic [WU_W-1:0]       req_unit  = '0;
   logic                  rsp_ready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   hst_req_if req_bus ();
   hst_rsp_if rsp_bus ();
   hst_csr_if csr_bus ();

   assign req_bus.valid      = req_valid;
   assign req_bus.unit_index = req_unit;
   assign rsp_bus.ready      = rsp_ready;
   assign csr_bus.valid      = csr_valid;
   assign csr_bus.index      = csr_index;
   assign csr_bus.data       = csr_data;

   head_split_tile_address_gen DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // Work units waiting to be offered, and descriptor words still owed by the block.
   logic [WU_W-1:0] queued_units[$];
   tile_desc_type   due_tiles[$];

   // Our own copy of the register file, updated as each write is accepted.
   cfg_type shadow_cfg;

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  req_gap     = 0;
   int  rsp_stall   = 0;
   logic req_fire   = 1'b0;
   // When set, neither side idles, so the block is run flat out for a phase.
   logic no_gaps    = 1'b0;

   // Length of an idle stretch: mostly short, now and then a long one.
   function automatic int idle_span();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Works out the whole run of descriptor words for one accepted work unit and
   // appends them to the words still owed. The unit is split into group and
   // block by group_count, the block into batch and row by rows_per_batch, and a
   // divisor of zero behaves as one. The group stride uses the full product of
   // heads and tiles per head even where the run itself is cut to the maximum.
   function automatic void predict_tile_run(input logic [WU_W-1:0] wu);
      logic [31:0]   gdiv;
      logic [31:0]   rdiv;
      logic [31:0]   blk;
      logic [31:0]   grp;
      logic [31:0]   batch;
      logic [31:0]   row;
      logic [31:0]   tiles_in_group;
      logic [31:0]   run_len;
      logic [31:0]   base;
      tile_desc_type d;
      gdiv  = (shadow_cfg.group_count == '0) ? 32'd1 : 32'(shadow_cfg.group_count);
      rdiv  = (shadow_cfg.rows_per_batch == '0) ? 32'd1 : 32'(shadow_cfg.rows_per_batch);
      blk   = 32'(wu) / gdiv;
      grp   = 32'(wu) % gdiv;
      batch = blk / rdiv;
      row   = blk % rdiv;
      tiles_in_group = 32'(shadow_cfg.heads_in_group) * 32'(shadow_cfg.tiles_per_head);
      run_len = (tiles_in_group > 32'(MAX_RUN_TILES)) ? 32'(MAX_RUN_TILES)
                                                      : tiles_in_group;
      // The raw rows_per_batch goes into the batch stride, zero included.
      base = batch * (32'(shadow_cfg.rows_per_batch) * 32'(shadow_cfg.tiles_per_row))
           + row * 32'(shadow_cfg.tiles_per_row)
           + grp * tiles_in_group;
      for (int i = 0; i < run_len; i++) begin
         d.page_index     = base + 32'(i);
         d.local_offset   = OFFS_W'(32'(i) * 32'(shadow_cfg.tile_bytes));
         d.tensor_address = shadow_cfg.output_address;
         d.run_last       = (32'(i) + 32'd1 == run_len);
         due_tiles.push_back(d);
      end
   endfunction

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
   endtask

   // Request driver. Inputs move on the falling edge only. Once a word has been
   // taken the driver may hold valid low for a random gap before offering the
   // next work unit; a word on offer is never withdrawn.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0 || queued_units.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
            end
         end else begin
            req_valid <= 1'b1;
            req_unit  <= queued_units[0];
            queued_units.delete(0);
            req_gap   <= (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_span();
         end
      end
   end

   // Response back-pressure: ready drops now and then for a random stretch, and
   // stays up throughout a phase that runs without gaps.
   always @(negedge clock) begin
      if (reset || no_gaps) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= idle_span() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Both channels are sampled on the rising edge: an accepted request
   // word is turned into the words it should cause, and each accepted response
   // word is held against the oldest word still owed.
   always @(posedge clock) begin
      tile_desc_type want;
      req_fire <= !reset && req_valid && req_bus.ready;
      if (!reset) begin
         if (req_valid && req_bus.ready) begin
            predict_tile_run(req_unit);
         end
         if (rsp_bus.valid && rsp_ready) begin
            if (due_tiles.size() == 0) begin
               fail_count++;
               $display("%0t: response word, expected none, got page_index %h",
                        $time, rsp_bus.page_index);
            end else begin
               want = due_tiles[0];
               due_tiles.delete(0);
               if (rsp_bus.page_index !== want.page_index) begin
                  flag_field("page_index", want.page_index, rsp_bus.page_index);
               end
               if (rsp_bus.local_offset !== want.local_offset) begin
                  flag_field("local_offset", 32'(want.local_offset),
                             32'(rsp_bus.local_offset));
               end
               if (rsp_bus.tensor_address !== want.tensor_address) begin
                  flag_field("tensor_address", want.tensor_address,
                             rsp_bus.tensor_address);
               end
               if (rsp_bus.run_last !== want.run_last) begin
                  flag_field("run_last", 32'(want.run_last), 32'(rsp_bus.run_last));
               end
            end
         end
      end
   end

   // Guard against a hang: a run that outlives the limit has failed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One register write on the configuration port. The shadow copy follows the
   // block at the edge where the word is taken, using the same field masks.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_GROUP_COUNT:    shadow_cfg.group_count    = value[GC_W-1:0];
         REG_HEADS_IN_GROUP: shadow_cfg.heads_in_group = value[GC_W-1:0];
         REG_TILES_PER_HEAD: shadow_cfg.tiles_per_head = value[GC_W-1:0];
         REG_TILES_PER_ROW:  shadow_cfg.tiles_per_row  = value[TPR_W-1:0];
         REG_ROWS_PER_BATCH: shadow_cfg.rows_per_batch = value[RPB_W-1:0];
         REG_TILE_BYTES:     shadow_cfg.tile_bytes     = value[TB_W-1:0];
         REG_OUTPUT_ADDRESS: shadow_cfg.output_address = value[ADDR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] groups, input logic [31:0] heads,
                                input logic [31:0] tiles, input logic [31:0] row_tiles,
                                input logic [31:0] rows, input logic [31:0] bytes,
                                input logic [31:0] address);
      write_reg(REG_GROUP_COUNT, groups);
      write_reg(REG_HEADS_IN_GROUP, heads);
      write_reg(REG_TILES_PER_HEAD, tiles);
      write_reg(REG_TILES_PER_ROW, row_tiles);
      write_reg(REG_ROWS_PER_BATCH, rows);
      write_reg(REG_TILE_BYTES, bytes);
      write_reg(REG_OUTPUT_ADDRESS, address);
   endtask

   // A random register value: usually a typical one, but the ends of the
   // legal range, zero and a full 32-bit word (cut down by the block) all occur.
   function automatic logic [31:0] rand_reg(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [31:0] usual_hi);
      case ($urandom_range(0, 15))
         0:       return lo;
         1:       return hi;
         2:       return 32'd0;
         3:       return $urandom;
         default: return $urandom_range(lo, usual_hi);
      endcase
   endfunction

   // Random work unit: the full 24-bit range, small indices that keep batch
   // and row low, and values close to all ones.
   function automatic logic [WU_W-1:0] rand_unit();
      case ($urandom_range(0, 3))
         0, 1:    return WU_W'($urandom);
         2:       return WU_W'($urandom_range(0, 4095));
         default: return {WU_W{1'b1}} - WU_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Waits until every work unit has been taken and every word owed has come
   // back, then lets the block settle, since a unit with an empty run may still
   // be passing through the front end.
   task automatic drain();
      while (queued_units.size() != 0 || req_valid || due_tiles.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      shadow_cfg = '{group_count:    RST_GROUP_COUNT,
                     heads_in_group: RST_HEADS_IN_GROUP,
                     tiles_per_head: RST_TILES_PER_HEAD,
                     tiles_per_row:  RST_TILES_PER_ROW,
                     rows_per_batch: RST_ROWS_PER_BATCH,
                     tile_bytes:     RST_TILE_BYTES,
                     output_address: RST_OUTPUT_ADDRESS};
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first, with the extremes and alternating patterns of
      // the work unit, and values either side of a group boundary.
      queued_units = '{24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA,
                       24'd15, 24'd16, 24'd255};
      drain();

      // Both divisors zero, so they act as one; a group of 4096 tiles whose run
      // is cut to the maximum; register values above their stated range; and
      // a write to an index outside the map, which must be ignored.
      load_settings(0, 64, 64, 8191, 0, 131071, 32'hFFFF_FFFF);
      write_reg(REG_UNUSED, $urandom);
      queued_units = '{24'h000000, 24'hFFFFFF, 24'h123456};
      drain();

      // Every register at its minimum: runs of a single word, always the last.
      load_settings(1, 1, 1, 1, 1, 1, 0);
      queued_units = '{24'h000000, 24'hFFFFFF, 24'h000001};
      drain();

      // Most counts at the upper end of their legal range, and a run of exactly the maximum length.
      load_settings(64, 1, 64, 4096, 4096, 65536, 32'h8000_0001);
      queued_units = '{24'hFFFFFF, 24'd63, 24'd64, 24'h040000};
      drain();

      // Empty runs from either factor being zero, then a run just over the cap.
      write_reg(REG_HEADS_IN_GROUP, 0);
      write_reg(REG_TILES_PER_HEAD, 5);
      queued_units = '{24'd7, 24'hFFFFFF};
      drain();
      write_reg(REG_HEADS_IN_GROUP, 3);
      write_reg(REG_TILES_PER_HEAD, 0);
      queued_units = '{24'd9, 24'd100};
      drain();
      write_reg(REG_TILES_PER_HEAD, 22);
      queued_units = '{24'd5};
      drain();

      // Random phases: fresh settings for each, and now and then a phase that
      // runs without any idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         load_settings(rand_reg(1, 64, 64), rand_reg(1, 64, 8), rand_reg(1, 64, 8),
                       rand_reg(1, 4096, 4096), rand_reg(1, 4096, 4096),
                       rand_reg(1, 65536, 65536), rand_reg(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, $urandom);
         end
         for (int n = 0; n < PHASE_UNITS; n++) begin
            queued_units.push_back(rand_unit());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
